@@ hw/rtl/mat_pkg.sv @@
// ----------------------------------------------------------------------------
// mat_pkg: shared types and constants of the MAC activity table
// Widths, kind codes and the queue entry that joins front and back.
// ----------------------------------------------------------------------------
package mat_pkg;
	localparam int TableDepth = 32;
	localparam int IdxW       = $clog2(TableDepth);
	localparam int UsedW      = $clog2(TableDepth + 1);
	localparam int CountW     = 16;
	localparam int MacW       = 48;
	localparam int TimeW      = 32;
	localparam int WinW       = 16;
	localparam logic [2:0] ColorFirst = 3'd1;
	localparam logic [2:0] ColorLast  = 3'd6;
	localparam logic [WinW-1:0] WindowReset = 16'd10;
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
	localparam logic [TimeW-1:0] TotalMax = {TimeW{1'b1}};

	localparam logic [1:0] KindAck     = 2'd0;
	localparam logic [1:0] KindReport  = 2'd1;
	localparam logic [1:0] KindSummary = 2'd2;

	localparam logic OpPacket   = 1'b0;
	localparam logic OpInterval = 1'b1;

	localparam int RegWindow = 0;

	typedef struct packed {
		logic             op;
		logic [MacW-1:0]  mac;
		logic [TimeW-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [MacW-1:0]   mac;
		logic [4:0]        index;
		logic [2:0]        color;
		logic [15:0]       count;
		logic [5:0]        active;
		logic [TimeW-1:0]  total;
		logic              is_new;
		logic              dropped;
		logic              last;
	} res_t;
endpackage

@@ hw/rtl/mat_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// mat_cmd_fifo: two-entry command queue
// Decouples the input handshake from the table engine.
// ----------------------------------------------------------------------------
module mat_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mat_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output mat_pkg::cmd_t out_cmd
);
	mat_pkg::cmd_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ hw/rtl/mat_engine.sv @@
// ----------------------------------------------------------------------------
// mat_engine: table search, update and interval sweep
// Walks the table one slot at a time, a read state then a check state per slot; drives a one-deep result register.
// ----------------------------------------------------------------------------
module mat_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  mat_pkg::cmd_t                cmd,
	input  logic [mat_pkg::WinW-1:0]     window,
	output logic                         res_valid,
	input  logic                         res_ready,
	output mat_pkg::res_t                res
);
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_EMIT  = 5'b01000,
		ST_CLEAR = 5'b10000
	} state_t;

	logic [mat_pkg::MacW-1:0]   mac_mem   [mat_pkg::TableDepth];
	logic [mat_pkg::TimeW-1:0]  seen_mem  [mat_pkg::TableDepth];
	logic [mat_pkg::CountW-1:0] count_mem [mat_pkg::TableDepth];
	logic [2:0]                 color_mem [mat_pkg::TableDepth];

	state_t                     state_q;
	mat_pkg::cmd_t              cmd_q;
	logic [mat_pkg::UsedW-1:0]  used_q, ptr_q, active_q;
	logic [2:0]                 color_q;
	logic [mat_pkg::TimeW-1:0]  total_q;
	logic [mat_pkg::MacW-1:0]   rd_mac_q;
	logic [mat_pkg::TimeW-1:0]  rd_seen_q;
	logic [mat_pkg::CountW-1:0] rd_count_q;
	logic [2:0]                 rd_color_q;
	logic [mat_pkg::IdxW-1:0]   idx;
	logic                       busy_out, hit, act, at_end;
	logic [mat_pkg::TimeW-1:0]  diff;
	logic [mat_pkg::CountW-1:0] cnt_inc;

	assign idx       = ptr_q[mat_pkg::IdxW-1:0];
	assign busy_out  = res_valid && !res_ready;
	assign cmd_ready = (state_q == ST_IDLE) && !busy_out;
	assign at_end    = (ptr_q >= used_q);
	assign hit       = (rd_mac_q == cmd_q.mac);
	assign diff      = cmd_q.now - rd_seen_q;
	assign act       = (cmd_q.now < rd_seen_q) ||
		(diff < {{(mat_pkg::TimeW-mat_pkg::WinW){1'b0}}, window});
	assign cnt_inc   = (rd_count_q == mat_pkg::CountMax) ? rd_count_q
		: rd_count_q + 1'b1;

	// table reads, registered
	always_ff @(posedge clk) begin
		rd_mac_q   <= mac_mem[idx];
		rd_seen_q  <= seen_mem[idx];
		rd_count_q <= count_mem[idx];
		rd_color_q <= color_mem[idx];
	end

	// table writes
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK && cmd_q.op == mat_pkg::OpPacket && !busy_out) begin
			if (!at_end && hit) begin
				count_mem[idx] <= cnt_inc;
				seen_mem[idx]  <= cmd_q.now;
			end else if (at_end && used_q < mat_pkg::UsedW'(mat_pkg::TableDepth)) begin
				mac_mem[idx]   <= cmd_q.mac;
				seen_mem[idx]  <= cmd_q.now;
				count_mem[idx] <= mat_pkg::CountW'(1);
				color_mem[idx] <= color_q;
			end
		end else if (state_q == ST_CLEAR) begin
			count_mem[idx] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			color_q   <= mat_pkg::ColorFirst;
			total_q   <= '0;
			ptr_q     <= '0;
			active_q  <= '0;
			res_valid <= 1'b0;
			cmd_q     <= '0;
			res       <= '0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						cmd_q    <= cmd;
						ptr_q    <= '0;
						active_q <= '0;
						state_q  <= ST_READ;
						if (cmd.op == mat_pkg::OpPacket && total_q != mat_pkg::TotalMax)
							total_q <= total_q + 1'b1;
					end
				end
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (!busy_out) begin
						res <= '0;
						if (cmd_q.op == mat_pkg::OpPacket) begin
							if (!at_end && !hit) begin
								ptr_q   <= ptr_q + 1'b1;
								state_q <= ST_READ;
							end else begin
								res_valid    <= 1'b1;
								res.kind     <= mat_pkg::KindAck;
								res.mac      <= cmd_q.mac;
								res.last     <= 1'b1;
								state_q      <= ST_IDLE;
								if (!at_end) begin
									res.index <= 5'(idx);
									res.color <= rd_color_q;
									res.count <= 16'(cnt_inc);
								end else if (used_q < mat_pkg::UsedW'(mat_pkg::TableDepth)) begin
									res.index  <= 5'(idx);
									res.color  <= color_q;
									res.count  <= 16'd1;
									res.is_new <= 1'b1;
									used_q     <= used_q + 1'b1;
									color_q    <= (color_q >= mat_pkg::ColorLast) ?
										mat_pkg::ColorFirst : color_q + 1'b1;
								end else begin
									res.dropped <= 1'b1;
								end
							end
						end else if (at_end) begin
							res_valid    <= 1'b1;
							res.kind     <= mat_pkg::KindSummary;
							res.active   <= 6'(active_q);
							res.total    <= total_q;
							res.last     <= 1'b1;
							total_q      <= '0;
							ptr_q        <= '0;
							state_q      <= ST_CLEAR;
						end else begin
							if (act) begin
								res_valid  <= 1'b1;
								res.kind   <= mat_pkg::KindReport;
								res.mac    <= rd_mac_q;
								res.index  <= 5'(idx);
								res.color  <= rd_color_q;
								res.count  <= 16'(rd_count_q);
								active_q   <= active_q + 1'b1;
							end
							ptr_q   <= ptr_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_CLEAR: begin
					if (ptr_q == mat_pkg::UsedW'(mat_pkg::TableDepth - 1)) begin
						state_q <= ST_IDLE;
					end
					ptr_q <= ptr_q + 1'b1;
				end
				ST_EMIT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/mac_activity_table_core.sv @@
// ----------------------------------------------------------------------------
// mac_activity_table_core: station MAC table with per-interval activity
// Learns MACs in insertion order and reports active stations per interval.
// ----------------------------------------------------------------------------
// A packet beat compares the table slots in turn, each with a read state and a
// check state, plus a final read and check when the MAC is new or dropped, and
// the engine then returns to idle before the next beat is taken; an interval
// beat walks every used slot the same way and then emits the summary, followed
// by a clear sweep over all 32 table slots and the return to idle. The walk
// reads one slot at a time from the table memories, and the check state waits
// while the consumer holds off a waiting result. A
// two-entry command queue takes new beats while the engine works, and a
// result register holds each result until the consumer takes it.
module mac_activity_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [47:0] mac,
	input  logic [31:0] time_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [47:0] entry_mac,
	output logic [4:0]  entry_index,
	output logic [2:0]  color,
	output logic [15:0] packet_count,
	output logic [5:0]  active_count,
	output logic [31:0] total_packets,
	output logic        is_new,
	output logic        dropped,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	mat_pkg::cmd_t in_cmd, q_cmd;
	mat_pkg::res_t res;
	logic          q_valid, q_ready;
	logic [mat_pkg::WinW-1:0] window_q;

	assign in_cmd = '{op: operation, mac: mac, now: time_seconds};

	// register file: window only, at byte address zero
	assign pready = 1'b1;
	assign prdata = (paddr == 2'(mat_pkg::RegWindow * 4)) ? {16'd0, window_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= mat_pkg::WindowReset;
		end else if (psel && penable && pwrite &&
			paddr == 2'(mat_pkg::RegWindow * 4)) begin
			window_q <= pwdata[mat_pkg::WinW-1:0];
		end
	end

	mat_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
		.out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
	);

	mat_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.window(window_q),
		.res_valid(out_valid), .res_ready(out_ready), .res(res)
	);

	assign kind          = res.kind;
	assign entry_mac     = res.mac;
	assign entry_index   = res.index;
	assign color         = res.color;
	assign packet_count  = res.count;
	assign active_count  = res.active;
	assign total_packets = res.total;
	assign is_new        = res.is_new;
	assign dropped       = res.dropped;
	assign last          = res.last;
endmodule
